// ----- rtl/core/segment_window_median_tracker_macros.svh -----
// Assertion macros for the segment window median tracker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SEGMENT_WINDOW_MEDIAN_TRACKER_MACROS_SVH
`define SEGMENT_WINDOW_MEDIAN_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

`define SWMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define SWMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SWMT_ASSERT_IMP(lbl, ante, cons)

`define SWMT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/swmt_pkg.sv -----
`default_nettype none

package swmt_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned WIN_W       = 5;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_FIELD_W = SEQ_W + SEQ_W + WIN_W + DUR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [WIN_W-1:0] WIN_RESET  = 5'd16;
  localparam logic [DUR_W-1:0] HINT_FLOOR = 16'd100;

  typedef struct packed {
    logic accept;
    logic scan;
    logic update;
    logic win_rd;
    logic win_cap;
    logic sel;
    logic out_load;
  } swmt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic sel_done;
    logic out_free;
  } swmt_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/swmt_datapath.sv -----
`default_nettype none
`include "segment_window_median_tracker_macros.svh"

module swmt_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swmt_pkg::WIN_W-1:0]           cfg_wdata_i,
  input  logic [swmt_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  input  swmt_pkg::swmt_cmd_t                  cmd_i,
  output swmt_pkg::swmt_status_t               status_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [swmt_pkg::OUT_TDATA_W-1:0]     m_data_o,
  output logic                                 m_user_o
);

  localparam int unsigned DEPTH = swmt_pkg::DEPTH;
  localparam int unsigned PTR_W = swmt_pkg::PTR_W;
  localparam int unsigned CNT_W = swmt_pkg::CNT_W;
  localparam int unsigned SEQ_W = swmt_pkg::SEQ_W;
  localparam int unsigned DUR_W = swmt_pkg::DUR_W;
  localparam int unsigned WIN_W = swmt_pkg::WIN_W;
  localparam int unsigned PAD_W = swmt_pkg::OUT_TDATA_W - swmt_pkg::OUT_FIELD_W;

  logic [WIN_W-1:0] win_q;
  logic [SEQ_W-1:0] in_seq_q;
  logic [DUR_W-1:0] in_dur_q;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SEQ_W-1:0] latest_q;
  logic [SEQ_W-1:0] wstart_q;

  logic [SEQ_W-1:0] seq_mem [DEPTH];
  logic [SEQ_W-1:0] rd_data_q;
  logic [DUR_W-1:0] dur_q [DEPTH];

  logic [CNT_W-1:0] idx_q;
  logic             cmp_vld_q;
  logic [PTR_W-1:0] cmp_slot_q;
  logic             hit_q;
  logic [PTR_W-1:0] hit_slot_q;

  logic [DUR_W-1:0] lane_q [DEPTH];
  logic [DEPTH-1:0] elig_q;
  logic [CNT_W-1:0] k_q;
  logic [DUR_W-1:0] hint_q;
  logic [PTR_W-1:0] sel_cnt_q;

  logic                         m_valid_q;
  logic [swmt_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                         out_user_q;

  // scan
  logic             issue;
  logic [PTR_W-1:0] scan_addr;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_en;
  logic             eq;

  assign issue     = cmd_i.scan && (idx_q < cnt_q);
  assign scan_addr = ptr_q + idx_q[PTR_W-1:0];
  assign rd_addr   = cmd_i.win_rd ? ptr_q : scan_addr;
  assign rd_en     = issue || cmd_i.win_rd;
  assign eq        = cmp_vld_q && (rd_data_q == in_seq_q);

  // append and trim
  logic [CNT_W-1:0] eff;
  logic             full;
  logic [PTR_W-1:0] p0;
  logic [CNT_W-1:0] hc0, hc1, drop;
  logic [PTR_W-1:0] wslot;

  always_comb begin
    eff   = (32'(win_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(win_q);
    full  = (cnt_q >= CNT_W'(DEPTH));
    p0    = full ? ptr_q + PTR_W'(1) : ptr_q;
    hc0   = full ? cnt_q - CNT_W'(1) : cnt_q;
    wslot = p0 + hc0[PTR_W-1:0];
    hc1   = hc0 + CNT_W'(1);
    drop  = (hc1 > eff) ? hc1 - eff : '0;
    ptr_d = p0 + drop[PTR_W-1:0];
    cnt_d = (hc1 > eff) ? eff : hc1;
  end

  // lane load and rank test
  logic [DEPTH-1:0] elig_load;
  logic [DEPTH-1:0] lt, le;
  logic [CNT_W-1:0] n_less, n_leq;
  logic [PTR_W-1:0] off;

  always_comb begin
    elig_load = '0;
    lt        = '0;
    le        = '0;
    off       = '0;
    for (int i = 0; i < DEPTH; i++) begin
      off          = PTR_W'(i) - ptr_q;
      elig_load[i] = (CNT_W'(off) < cnt_q) && (dur_q[i] > swmt_pkg::HINT_FLOOR);
      lt[i]        = elig_q[i] && (lane_q[i] < lane_q[0]);
      le[i]        = elig_q[i] && (lane_q[i] <= lane_q[0]);
    end
    n_less = CNT_W'($countones(lt));
    n_leq  = CNT_W'($countones(le));
  end

  always_comb begin
    status_o.scan_done = eq || (!cmp_vld_q && (idx_q >= cnt_q));
    status_o.sel_done  = (sel_cnt_q == PTR_W'(DEPTH - 1));
    status_o.out_free  = !m_valid_q || m_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= swmt_pkg::WIN_RESET;
      ptr_q     <= '0;
      cnt_q     <= '0;
      latest_q  <= '0;
      wstart_q  <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      sel_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q     <= issue ? idx_q + CNT_W'(1) : idx_q;
        cmp_vld_q <= issue;
        if (eq) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.update) begin
        if (in_seq_q > latest_q) begin
          latest_q <= in_seq_q;
        end
        if (!hit_q) begin
          ptr_q <= ptr_d;
          cnt_q <= cnt_d;
        end
      end
      if (cmd_i.win_cap) begin
        wstart_q  <= (cnt_q == '0) ? '0 : rd_data_q;
        sel_cnt_q <= '0;
      end else if (cmd_i.sel) begin
        sel_cnt_q <= sel_cnt_q + PTR_W'(1);
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_seq_q <= in_tdata_i[SEQ_W-1:0];
      in_dur_q <= in_tdata_i[SEQ_W+DUR_W-1:SEQ_W];
    end
    if (cmd_i.scan) begin
      cmp_slot_q <= scan_addr;
      if (eq) begin
        hit_slot_q <= cmp_slot_q;
      end
    end
    if (cmd_i.update) begin
      if (hit_q) begin
        dur_q[hit_slot_q] <= in_dur_q;
      end else begin
        dur_q[wslot] <= in_dur_q;
      end
    end
    if (cmd_i.win_cap) begin
      for (int i = 0; i < DEPTH; i++) begin
        lane_q[i] <= dur_q[i];
      end
      elig_q <= elig_load;
      k_q    <= CNT_W'($countones(elig_load) >> 1);
      hint_q <= '0;
    end else if (cmd_i.sel) begin
      for (int i = 0; i < DEPTH; i++) begin
        lane_q[i] <= lane_q[(i + 1) % DEPTH];
      end
      elig_q <= {elig_q[0], elig_q[DEPTH-1:1]};
      if (elig_q[0] && (n_less <= k_q) && (k_q < n_leq)) begin
        hint_q <= lane_q[0];
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{PAD_W{1'b0}}, hint_q, WIN_W'(cnt_q), wstart_q, latest_q};
      out_user_q <= hit_q;
    end
  end

  // sequence number store
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !hit_q) begin
      seq_mem[wslot] <= in_seq_q;
    end
    if (rd_en) begin
      rd_data_q <= seq_mem[rd_addr];
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = out_user_q;

  `SWMT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))
  `SWMT_ASSERT_NEXT(a_append_trim, cmd_i.update && !hit_q, cnt_q <= $past(eff))
  `SWMT_ASSERT_NEXT(a_refresh_keeps, cmd_i.update && hit_q,
                    (cnt_q == $past(cnt_q)) && (ptr_q == $past(ptr_q)))
  `SWMT_ASSERT_NEXT(a_load_shows, cmd_i.out_load, m_valid_q)

endmodule

`default_nettype wire

// ----- rtl/core/swmt_ctrl.sv -----
`default_nettype none

module swmt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  swmt_pkg::swmt_status_t status_i,
  output swmt_pkg::swmt_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StUpd   = 3'd2;
  localparam logic [2:0] StWinRd = 3'd3;
  localparam logic [2:0] StWinCp = 3'd4;
  localparam logic [2:0] StSel   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.accept   = in_valid_i && in_ready_o;
    cmd_o.scan     = (state_q == StScan);
    cmd_o.update   = (state_q == StUpd);
    cmd_o.win_rd   = (state_q == StWinRd);
    cmd_o.win_cap  = (state_q == StWinCp);
    cmd_o.sel      = (state_q == StSel);
    cmd_o.out_load = (state_q == StOut) && status_i.out_free;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StScan;
      StScan:  if (status_i.scan_done) state_d = StUpd;
      StUpd:   state_d = StWinRd;
      StWinRd: state_d = StWinCp;
      StWinCp: state_d = StSel;
      StSel:   if (status_i.sel_done) state_d = StOut;
      StOut:   if (status_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/segment_window_median_tracker.sv -----
`default_nettype none

// Rolling window of up to sixteen media segments. Each input transfer carries a
// sequence number and a duration; a held sequence number refreshes its duration,
// a new one is appended and the window trimmed to window_size. Each item gives
// one output transfer with the latest sequence number, window start, entry count,
// the upper median of durations above 100 ms and a refresh flag in tuser. For each
// item the held entries are scanned one per cycle through the sequence-number
// memory port, then sixteen rank-selection steps run over a rotating copy of the
// durations. The next item is accepted while a result still waits on the output
// side.
module segment_window_median_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swmt_pkg::WIN_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] segment_seq, [47:32] duration_ms
  input  logic [swmt_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [31:0] latest_seq_out, [63:32] window_start_out, [68:64] entry_count,
  // [84:69] duration_hint_ms, rest zero
  output logic [swmt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [0] was_refresh
  output logic                                 m_axis_tuser_o
);

  swmt_pkg::swmt_cmd_t    cmd;
  swmt_pkg::swmt_status_t status;

  swmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swmt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_user_o    (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = swmt_pkg::DEPTH;
  localparam int unsigned SEQ_W       = swmt_pkg::SEQ_W;
  localparam int unsigned DUR_W       = swmt_pkg::DUR_W;
  localparam int unsigned WIN_W       = swmt_pkg::WIN_W;
  localparam int unsigned IN_TDATA_W  = swmt_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = swmt_pkg::OUT_TDATA_W;
  localparam logic [WIN_W-1:0] WIN_RESET  = swmt_pkg::WIN_RESET;
  localparam logic [DUR_W-1:0] HINT_FLOOR = swmt_pkg::HINT_FLOOR;

  typedef struct {
    logic [SEQ_W-1:0] seq;
    logic [DUR_W-1:0] dur;
    bit               hold;
  } segment_t;

  typedef struct packed {
    logic [SEQ_W-1:0] latest;
    logic [SEQ_W-1:0] start;
    logic [WIN_W-1:0] count;
    logic [DUR_W-1:0] hint;
    logic             refresh;
  } window_status_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [WIN_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  segment_window_median_tracker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // tracker model state
  logic [SEQ_W-1:0] seq_mem [DEPTH];
  logic [DUR_W-1:0] dur_mem [DEPTH];
  int unsigned      oldest_slot;
  int unsigned      held;
  logic [SEQ_W-1:0] max_seq;
  logic [SEQ_W-1:0] window_start;
  logic [WIN_W-1:0] window_size;

  segment_t         segment_q[$];
  window_status_t   status_q[$];
  segment_t         next_segment;
  window_status_t   got_status;
  window_status_t   want_status;
  int               in_flight = 0;
  int               mismatch_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;

  logic [SEQ_W-1:0] gen_seq;
  logic [SEQ_W-1:0] seq_history[$];

  function automatic window_status_t track_segment(logic [SEQ_W-1:0] seq,
                                                   logic [DUR_W-1:0] dur);
    window_status_t   st;
    int unsigned      eff;
    int unsigned      i;
    int unsigned      j;
    int unsigned      n;
    int unsigned      slot;
    bit               hit;
    logic [DUR_W-1:0] d;
    logic [DUR_W-1:0] vals [DEPTH];
    eff = (window_size > DEPTH) ? DEPTH : window_size;
    hit = 1'b0;
    for (i = 0; i < held && !hit; i++) begin
      slot = (oldest_slot + i) % DEPTH;
      if (seq_mem[slot] == seq) begin
        dur_mem[slot] = dur;
        hit = 1'b1;
      end
    end
    if (seq > max_seq) max_seq = seq;
    if (!hit) begin
      if (held >= DEPTH) begin
        oldest_slot = (oldest_slot + 1) % DEPTH;
        held--;
      end
      slot = (oldest_slot + held) % DEPTH;
      seq_mem[slot] = seq;
      dur_mem[slot] = dur;
      held++;
      while (held > eff) begin
        oldest_slot = (oldest_slot + 1) % DEPTH;
        held--;
      end
      window_start = (held != 0) ? seq_mem[oldest_slot] : '0;
    end
    // upper median of durations above the floor
    n = 0;
    for (i = 0; i < held; i++) begin
      d = dur_mem[(oldest_slot + i) % DEPTH];
      if (d > HINT_FLOOR) begin
        j = n;
        while (j > 0 && vals[j-1] > d) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = d;
        n++;
      end
    end
    st.latest  = max_seq;
    st.start   = window_start;
    st.count   = held[WIN_W-1:0];
    st.hint    = (n != 0) ? vals[n/2] : '0;
    st.refresh = hit;
    return st;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (segment_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct &&
          !(segment_q[0].hold && (s_axis_tvalid_i || in_flight != 0))) begin
        next_segment = segment_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {next_segment.dur, next_segment.seq};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) window_size = cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_status.latest  = m_axis_tdata_o[SEQ_W-1:0];
        got_status.start   = m_axis_tdata_o[2*SEQ_W-1:SEQ_W];
        got_status.count   = m_axis_tdata_o[2*SEQ_W+WIN_W-1:2*SEQ_W];
        got_status.hint    = m_axis_tdata_o[2*SEQ_W+WIN_W+DUR_W-1:2*SEQ_W+WIN_W];
        got_status.refresh = m_axis_tuser_o;
        if (status_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%t: unexpected result transfer latest=%h start=%h", $realtime,
                     got_status.latest, got_status.start);
        end else begin
          want_status = status_q.pop_front();
          if (got_status !== want_status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%t: mismatch", $realtime);
              $display("  latest  exp %h got %h", want_status.latest, got_status.latest);
              $display("  start   exp %h got %h", want_status.start, got_status.start);
              $display("  count   exp %0d got %0d", want_status.count, got_status.count);
              $display("  hint    exp %0d got %0d", want_status.hint, got_status.hint);
              $display("  refresh exp %0d got %0d", want_status.refresh,
                       got_status.refresh);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        status_q = {status_q, track_segment(s_axis_tdata_i[SEQ_W-1:0],
                                            s_axis_tdata_i[SEQ_W+DUR_W-1:SEQ_W])};
      in_flight <= in_flight + int'(s_axis_tvalid_i && s_axis_tready_o)
                   - int'(m_axis_tvalid_o && m_axis_tready_i);
    end
  end

  task automatic add_segment(logic [SEQ_W-1:0] seq, logic [DUR_W-1:0] dur,
                             bit hold = 1'b0);
    segment_t s;
    s.seq  = seq;
    s.dur  = dur;
    s.hold = hold;
    segment_q = {segment_q, s};
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (segment_q.size() != 0 || s_axis_tvalid_i || status_q.size() != 0);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_window(logic [WIN_W-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45) return DUR_W'($urandom_range(400, 90));
    if (r < 52) return HINT_FLOOR;
    if (r < 58) return HINT_FLOOR + DUR_W'(1);
    if (r < 62) return '0;
    if (r < 82) return DUR_W'($urandom_range(65535, 0));
    return DUR_W'($urandom_range(6000, 2000));
  endfunction

  task automatic fill_random(int count);
    int               k;
    int               hold_at;
    int unsigned      r;
    int unsigned      back;
    logic [SEQ_W-1:0] seq;
    hold_at = $urandom_range(count - 1, 0);
    if ($urandom_range(1, 0) != 0) gen_seq = $urandom();
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99, 0);
      if (r < 60 || seq_history.size() == 0) begin
        gen_seq = gen_seq + (($urandom_range(9, 0) == 0) ? $urandom_range(20, 2) : 1);
        seq = gen_seq;
      end else if (r < 80) begin
        back = $urandom_range((seq_history.size() < 20) ? seq_history.size() - 1 : 19, 0);
        seq = seq_history[seq_history.size() - 1 - back];
      end else if (r < 88) begin
        seq = gen_seq - $urandom_range(40, 1);
      end else if (r < 95) begin
        seq = $urandom();
      end else begin
        seq = ($urandom_range(1, 0) != 0) ? 32'hFFFF_FFFF - $urandom_range(15, 0)
                                          : SEQ_W'($urandom_range(15, 0));
      end
      seq_history = {seq_history, seq};
      if (seq_history.size() > 32) void'(seq_history.pop_front());
      add_segment(seq, pick_duration(), k == hold_at);
    end
  endtask

  initial begin
    logic [WIN_W-1:0] sizes [9];
    int               p;
    sizes = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd9, 5'd0, 5'd17, 5'd2, 5'd12};
    oldest_slot  = 0;
    held         = 0;
    max_seq      = '0;
    window_start = '0;
    window_size  = WIN_RESET;
    gen_seq      = '0;
    send_idle_pct  = 6;
    recv_stall_pct = 78;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, refresh, floor boundary, trim, saturation, shrink, empty window
    add_segment(32'h0, 16'h0);
    add_segment(32'hFFFF_FFFF, 16'hFFFF);
    add_segment(32'd5, HINT_FLOOR);
    add_segment(32'd6, HINT_FLOOR + DUR_W'(1));
    add_segment(32'd5, 16'd200);
    add_segment(32'hFFFF_FFFF, 16'h0);
    add_segment(32'd7, 16'd102, 1'b1);
    add_segment(32'd8, 16'hFFFF);
    write_window(5'd3);
    add_segment(32'd9, 16'd150);
    add_segment(32'd7, 16'd99);
    write_window(5'd31);
    add_segment(32'd10, 16'd250);
    add_segment(32'd11, 16'd300);
    add_segment(32'd12, 16'd350);
    write_window(5'd2);
    add_segment(32'd12, 16'd500);
    add_segment(32'd13, 16'd300);
    write_window(5'd0);
    add_segment(32'd14, 16'd400);
    add_segment(32'd14, 16'd500);
    add_segment(32'd13, 16'd1);

    for (p = 0; p < 9; p++) begin
      write_window(sizes[p]);
      if (p == 3) begin
        send_idle_pct  = 78;
        recv_stall_pct = 6;
      end else if (p == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      fill_random((sizes[p] == 0) ? 30 : 90);
    end

    wait_idle();
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
